// ----- design/bbl_pkg.sv -----
package bbl_pkg;

   // Request and response packing (request tdata: slot, value; response tdata: bin)
   localparam int unsigned REQ_TDATA_W = 40;
   localparam int unsigned RSP_TDATA_W = 8;
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned SLOT_W      = 4;
   localparam int unsigned BIN_W       = 4;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned CSR_DATA_W  = 5;

   // operation codes (carried on req_tuser)
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // configuration register indexes
   localparam logic CSR_CLAMP_ENABLE   = 1'b0;
   localparam logic CSR_BOUNDARY_COUNT = 1'b1;

   typedef struct packed {
      logic [BIN_W-1:0] bin;
      logic             error;
   } bbl_result_type;

endpackage

// ----- design/bbl_table_mem.sv -----
module bbl_table_mem #(
   parameter int unsigned TABLE_DEPTH = 16,
   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [IDX_W-1:0]   wr_addr,
   input  logic signed [31:0] wr_data,
   input  logic               rd_en,
   input  logic [IDX_W-1:0]   rd_addr,
   output logic signed [31:0] rd_data
);

   logic signed [31:0] mem [TABLE_DEPTH];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds when no read is issued; the controller relies on that while stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/bbl_search_ctrl.sv -----
module bbl_search_ctrl #(
   parameter int unsigned TABLE_DEPTH = 16,
   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH),
   localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_op,
   input  logic [bbl_pkg::SLOT_W-1:0]    req_slot,
   input  logic signed [31:0]            req_value,
   input  logic                          clamp_enable,
   input  logic [bbl_pkg::COUNT_W-1:0]   boundary_count,
   output logic                          mem_wr_en,
   output logic [IDX_W-1:0]              mem_wr_addr,
   output logic                          mem_rd_en,
   output logic [IDX_W-1:0]              mem_rd_addr,
   input  logic signed [31:0]            mem_rd_data,
   input  logic                          out_free,
   output logic                          res_valid,
   output bbl_pkg::bbl_result_type       res
);

   import bbl_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LO   = 2'd1;
   localparam logic [1:0] S_HI   = 2'd2;
   localparam logic [1:0] S_SCAN = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic signed [31:0] x_ff, x_in;
   logic signed [31:0] lo_ff, lo_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic               clamp_ff, clamp_in;
   logic [IDX_W-1:0]   bin_ff, bin_in;

   logic [31:0]        slot_wide;
   logic [31:0]        count_wide;
   logic [CNT_W-1:0]   n_sat;
   logic               slot_ok;
   logic [CNT_W-1:0]   bin_ext;
   logic [CNT_W-1:0]   nxt;
   logic [CNT_W-1:0]   last_idx;
   logic [CNT_W-1:0]   final_bin;

   assign slot_wide  = 32'(req_slot);
   assign count_wide = 32'(boundary_count);
   assign slot_ok    = slot_wide < TABLE_DEPTH;
   assign n_sat      = (count_wide > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(count_wide);
   assign bin_ext    = CNT_W'(bin_ff);
   assign nxt        = bin_ext + CNT_W'(1);
   assign last_idx   = n_ff - CNT_W'(1);

   function automatic logic [BIN_W-1:0] to_bin(input logic [CNT_W-1:0] b);
      logic [31:0] w;
      w = 32'(b);
      return w[BIN_W-1:0];
   endfunction

   always_comb begin
      state_in    = state_ff;
      x_in        = x_ff;
      lo_in       = lo_ff;
      n_in        = n_ff;
      clamp_in    = clamp_ff;
      bin_in      = bin_ff;
      req_ready   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = slot_wide[IDX_W-1:0];
      mem_rd_en   = 1'b0;
      mem_rd_addr = '0;
      res_valid   = 1'b0;
      res         = '0;
      final_bin   = bin_ext;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_op == OP_LOAD) begin
                  mem_wr_en = slot_ok;
               end else begin
                  x_in      = req_value;
                  n_in      = n_sat;
                  clamp_in  = clamp_enable;
                  mem_rd_en = 1'b1;
                  state_in  = S_LO;
               end
            end
         end
         S_LO: begin
            lo_in = mem_rd_data;
            if (n_ff == '0) begin
               if (out_free) begin
                  res_valid = 1'b1;
                  res.error = 1'b1;
                  state_in  = S_IDLE;
               end
            end else if (n_ff == CNT_W'(1)) begin
               if (out_free) begin
                  res_valid = 1'b1;
                  res.error = !clamp_ff && (x_ff != mem_rd_data);
                  state_in  = S_IDLE;
               end
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = last_idx[IDX_W-1:0];
               state_in    = S_HI;
            end
         end
         S_HI: begin
            if (x_ff < lo_ff || x_ff > mem_rd_data) begin
               if (out_free) begin
                  res_valid = 1'b1;
                  res.error = !clamp_ff;
                  if (clamp_ff && x_ff >= lo_ff) begin
                     res.bin = to_bin(n_ff - CNT_W'(2));
                  end
                  state_in = S_IDLE;
               end
            end else if (n_ff == CNT_W'(2)) begin
               if (out_free) begin
                  res_valid = 1'b1;
                  state_in  = S_IDLE;
               end
            end else begin
               bin_in      = '0;
               mem_rd_en   = 1'b1;
               mem_rd_addr = IDX_W'(1);
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            // mem_rd_data holds entry bin+1
            if (x_ff >= mem_rd_data && (nxt + CNT_W'(1)) < last_idx) begin
               bin_in      = nxt[IDX_W-1:0];
               mem_rd_en   = 1'b1;
               mem_rd_addr = IDX_W'(nxt + CNT_W'(1));
            end else begin
               final_bin = (x_ff >= mem_rd_data) ? nxt : bin_ext;
               if (out_free) begin
                  res_valid = 1'b1;
                  res.bin   = to_bin(final_bin);
                  state_in  = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      lo_ff    <= lo_in;
      n_ff     <= n_in;
      clamp_ff <= clamp_in;
      bin_ff   <= bin_in;
   end

endmodule

// ----- design/boundary_bin_lookup_unit.sv -----
// Histogram bin lookup over a table of up to TABLE_DEPTH signed Q16.16 boundaries.
// A load transaction (req_tuser = 0) writes req value into entry req slot; it returns
// no response. A lookup transaction (req_tuser = 1) returns one response with the bin
// index and an error flag. All table reads go through the single read port of the
// boundary memory, one entry per cycle, and the read data is registered: a lookup
// reads the first and last boundary, then scans inner boundaries upward until one
// lies above the sample. A lookup therefore answers after the first read with zero or
// one boundary in use, after the second read when the sample is outside the edges or
// two boundaries are in use, and otherwise after the scan of the inner entries.
// The input is taken again once the response sits in the output register, even if the
// consumer has not taken it; a finished lookup waits only if that register is still full.
// Configuration writes are taken at any time but belong to idle periods.
module boundary_bin_lookup_unit #(
   parameter int unsigned TABLE_DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [bbl_pkg::REQ_TDATA_W-1:0]   req_tdata,   // slot[3:0], value[35:4], zero pad
   input  logic                              req_tuser,   // operation
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [bbl_pkg::RSP_TDATA_W-1:0]   rsp_tdata,   // bin[3:0], zero pad
   output logic                              rsp_tuser,   // error
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [bbl_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import bbl_pkg::*;

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);

   logic                 clamp_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   bbl_result_type       rsp_ff, rsp_in;

   logic                 mem_wr_en;
   logic [IDX_W-1:0]     mem_wr_addr;
   logic                 mem_rd_en;
   logic [IDX_W-1:0]     mem_rd_addr;
   logic signed [31:0]   mem_rd_data;
   logic signed [31:0]   req_value;
   logic                 out_free;
   logic                 res_valid;
   bbl_result_type       res;

   assign req_value = req_tdata[SLOT_W +: VALUE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         clamp_ff <= 1'b0;
         count_ff <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_CLAMP_ENABLE:   clamp_ff <= csr_wdata[0];
            CSR_BOUNDARY_COUNT: count_ff <= csr_wdata[COUNT_W-1:0];
            default:            ;
         endcase
      end
   end

   bbl_table_mem #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_value),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bbl_search_ctrl #(.TABLE_DEPTH(TABLE_DEPTH)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .req_op         (req_tuser),
      .req_slot       (req_tdata[SLOT_W-1:0]),
      .req_value      (req_value),
      .clamp_enable   (clamp_ff),
      .boundary_count (count_ff),
      .mem_wr_en      (mem_wr_en),
      .mem_wr_addr    (mem_wr_addr),
      .mem_rd_en      (mem_rd_en),
      .mem_rd_addr    (mem_rd_addr),
      .mem_rd_data    (mem_rd_data),
      .out_free       (out_free),
      .res_valid      (res_valid),
      .res            (res)
   );

   // output register
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - BIN_W){1'b0}}, rsp_ff.bin};
   assign rsp_tuser  = rsp_ff.error;

endmodule

// ----- design/bbl_checker.sv -----
module bbl_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              req_tuser,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bbl_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tuser
);

   import bbl_pkg::*;

   logic req_fire;
   assign req_fire = req_tvalid && req_tready;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   a_err_bin_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("error response with nonzero bin");

   // a load never produces a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == OP_LOAD && !rsp_tvalid |=> !rsp_tvalid)
      else $error("response after load");

   // one lookup at a time, and no response appears straight after a lookup is accepted
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == OP_LOOKUP |=> !req_tready)
      else $error("input taken during lookup");

   a_lookup_latency: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tuser == OP_LOOKUP && !rsp_tvalid |=> !rsp_tvalid)
      else $error("lookup answered too early");

endmodule

bind boundary_bin_lookup_unit bbl_checker u_bbl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- sim/boundary_bin_lookup_unit_tb.sv -----
module boundary_bin_lookup_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bbl_pkg::*;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 400_000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASES      = 14;
   localparam int PHASE_ITEMS = 130;

   // Holds the expected bin for every accepted lookup, plus the block's table and registers.
   class bin_scoreboard;
      logic signed [VALUE_W-1:0] boundaries [DEPTH];
      bit                        clamp;
      logic [COUNT_W-1:0]        count;
      bbl_result_type            expected_q [$];
      int                        mismatches;

      function void set_register(logic index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_CLAMP_ENABLE) begin
            clamp = data[0];
         end else begin
            count = data[COUNT_W-1:0];
         end
      endfunction

      function int entries_in_use();
         return (count > DEPTH) ? DEPTH : int'(count);
      endfunction

      function bbl_result_type find_bin(logic signed [VALUE_W-1:0] x);
         bbl_result_type r;
         int             n;
         int             b;
         r.bin   = '0;
         r.error = 1'b0;
         b       = 0;
         n       = entries_in_use();
         if (n == 0) begin
            r.error = 1'b1;
         end else if (n == 1) begin
            if (!clamp && x != boundaries[0]) r.error = 1'b1;
         end else if (x < boundaries[0] || x > boundaries[n-1]) begin
            if (!clamp) begin
               r.error = 1'b1;
            end else if (x < boundaries[0]) begin
               b = 0;
            end else begin
               b = n - 2;
            end
         end else begin
            while (b + 1 < n - 1 && x >= boundaries[b+1]) b++;
         end
         if (!r.error) r.bin = BIN_W'(b);
         return r;
      endfunction

      function void note_request(logic op, logic [SLOT_W-1:0] slot,
                                 logic signed [VALUE_W-1:0] value);
         if (op == OP_LOAD) begin
            boundaries[slot] = value;
         end else begin
            expected_q.push_back(find_bin(value));
         end
      endfunction

      function void check_response(logic [BIN_W-1:0] bin, logic error);
         bbl_result_type exp_r;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response: bin %0d error %0d", bin, error);
            return;
         end
         exp_r = expected_q.pop_front();
         if (exp_r.bin !== bin || exp_r.error !== error) begin
            mismatches++;
            if (mismatches <= 10)
               $display("response mismatch: expected bin %0d error %0d, got bin %0d error %0d",
                        exp_r.bin, exp_r.error, bin, error);
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_wr_en  = 1'b0;
   logic                   csr_index  = 1'b0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   bin_scoreboard sb;
   bit            idle_on       = 1'b1;
   int            hold_requests = 0;
   int            holds_served  = 0;
   int            hold_left     = 0;
   int            stall_left    = 0;
   int            cycle_count   = 0;

   boundary_bin_lookup_unit #(.TABLE_DEPTH(DEPTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // transaction monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata[BIN_W-1:0], rsp_tuser);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[SLOT_W-1:0], req_tdata[SLOT_W +: VALUE_W]);
      end
   end

   // response side: random stall bursts, plus the long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holds_served != hold_requests) begin
         holds_served <= hold_requests;
         hold_left    <= HOLD_CYCLES - 1;
         rsp_tready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(logic op, logic [SLOT_W-1:0] slot, logic [VALUE_W-1:0] value);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_TDATA_W - VALUE_W - SLOT_W){1'b0}}, value, slot};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_lookup(logic [VALUE_W-1:0] value);
      send_item(OP_LOOKUP, SLOT_W'($urandom_range(0, DEPTH - 1)), value);
   endtask

   // loads issue no response, so allow the last one to finish before touching registers
   task automatic drain();
      req_tvalid <= 1'b0;
      // let the monitor record the last accepted transaction first
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
   endtask

   task automatic set_config(bit clamp, logic [CSR_DATA_W-1:0] count);
      drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CLAMP_ENABLE;
      // upper bits of the clamp write carry junk; only bit 0 counts
      csr_wdata <= {CSR_DATA_W'($urandom_range(0, 15)) << 1} | CSR_DATA_W'(clamp);
      @(posedge clock);
      sb.set_register(CSR_CLAMP_ENABLE, csr_wdata);
      csr_index <= CSR_BOUNDARY_COUNT;
      csr_wdata <= count;
      @(posedge clock);
      sb.set_register(CSR_BOUNDARY_COUNT, count);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_sorted_table();
      logic signed [VALUE_W-1:0] v [DEPTH];
      logic signed [VALUE_W-1:0] tmp;
      if ($urandom_range(0, 1) == 0) begin
         // tight table with repeated edges
         v[0] = $signed($urandom) >>> 1;
         for (int i = 1; i < DEPTH; i++)
            v[i] = v[i-1] + $urandom_range(0, 3) * 32'h1_0000 + $urandom_range(0, 1);
      end else begin
         for (int i = 0; i < DEPTH; i++) v[i] = $urandom;
         for (int i = 0; i < DEPTH - 1; i++)
            for (int j = 0; j < DEPTH - 1 - i; j++)
               if (v[j] > v[j+1]) begin
                  tmp    = v[j];
                  v[j]   = v[j+1];
                  v[j+1] = tmp;
               end
      end
      for (int i = 0; i < DEPTH; i++) send_item(OP_LOAD, SLOT_W'(i), v[i]);
   endtask

   // sample mostly at, next to, or between edges in use
   function automatic logic [VALUE_W-1:0] pick_sample();
      int     n;
      int     i;
      longint lo;
      longint hi;
      longint t;
      n = sb.entries_in_use();
      if (n < 1) n = DEPTH;
      i = $urandom_range(0, n - 1);
      case ($urandom_range(0, 9))
         0, 1:    return $urandom;
         2, 3, 4: return sb.boundaries[i];
         5:       return sb.boundaries[i] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
         default: begin
            lo = sb.boundaries[i];
            hi = sb.boundaries[(i + 1) % n];
            if (hi < lo) begin
               t  = lo;
               lo = hi;
               hi = t;
            end
            return VALUE_W'(lo + (longint'($urandom) % (hi - lo + 1)));
         end
      endcase
   endfunction

   initial begin
      bit                    clamp_list [10];
      logic [CSR_DATA_W-1:0] count_list [10];
      bit                    clamp;
      logic [CSR_DATA_W-1:0] count;

      clamp_list = '{0, 1, 0, 1, 0, 1, 0, 1, 1, 0};
      count_list = '{16, 16, 2, 2, 1, 1, 0, 0, 31, 17};
      sb = new();

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table after reset
      send_lookup(32'h8000_0000);
      send_lookup(32'h7FFF_FFFF);
      for (int i = 0; i < DEPTH; i++) begin
         if (i == 0)              send_item(OP_LOAD, SLOT_W'(i), 32'h8000_0000);
         else if (i == DEPTH - 1) send_item(OP_LOAD, SLOT_W'(i), 32'h7FFF_FFFF);
         else if (i == 8)         send_item(OP_LOAD, SLOT_W'(i), 32'h0);
         else                     send_item(OP_LOAD, SLOT_W'(i), (i - 7) * 32'h1_0000);
      end
      set_config(1'b0, 5'd16);
      send_lookup(32'h8000_0000);
      send_lookup(32'h7FFF_FFFF);
      send_lookup(32'h0);
      set_config(1'b0, 5'd1);
      send_lookup(32'h8000_0000);
      send_lookup(32'h0);
      set_config(1'b1, 5'd1);
      send_lookup(32'h0);
      // count above the table depth saturates
      set_config(1'b1, 5'd31);
      send_lookup(32'h5_0000);

      for (int p = 0; p < PHASES; p++) begin
         if (p < 10) begin
            clamp = clamp_list[p];
            count = count_list[p];
         end else begin
            clamp = $urandom_range(0, 1);
            count = $urandom_range(0, DEPTH);
         end
         set_config(clamp, count);
         idle_on = (p != 3) && (p < PHASES - 2);
         if ($urandom_range(0, 3) != 0) load_sorted_table();
         // fill the block while the response side is held off
         if (p == 3) hold_requests++;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 12)
               send_item(OP_LOAD, SLOT_W'($urandom_range(0, DEPTH - 1)),
                         ($urandom_range(0, 1) ? $urandom : pick_sample()));
            else
               send_lookup(pick_sample());
         end
      end

      drain();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
